// File: hdl/ini_line_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// INI line tokenizer assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef INI_LINE_TOKENIZER_ASSERT_SVH
`define INI_LINE_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ini_line_tokenizer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ILT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ini_line_tokenizer assertion failed");

`endif

// File: hdl/ilt_pkg.sv
// ----------------------------------------------------------------------------
// INI line tokenizer package
// Phase codes, token, line and error codes, byte constants, state and result types and byte class decoders.
// ----------------------------------------------------------------------------
`default_nettype none

package ilt_pkg;

  typedef enum logic [10:0] {
    PH_LEAD      = 11'b000_0000_0001,
    PH_SEC_FIRST = 11'b000_0000_0010,
    PH_SEC_NAME  = 11'b000_0000_0100,
    PH_OPT_NAME  = 11'b000_0000_1000,
    PH_PRE_EQ    = 11'b000_0001_0000,
    PH_POST_EQ   = 11'b000_0010_0000,
    PH_UNQ       = 11'b000_0100_0000,
    PH_QUOTED    = 11'b000_1000_0000,
    PH_Q_ESC     = 11'b001_0000_0000,
    PH_TRAIL     = 11'b010_0000_0000,
    PH_IGNORE    = 11'b100_0000_0000
  } phase_t;

  localparam logic [1:0] TK_SEC  = 2'd0;
  localparam logic [1:0] TK_OPT  = 2'd1;
  localparam logic [1:0] TK_VAL  = 2'd2;
  localparam logic [1:0] TK_DONE = 2'd3;

  localparam logic [1:0] LK_EMPTY   = 2'd0;
  localparam logic [1:0] LK_SECTION = 2'd1;
  localparam logic [1:0] LK_OPTION  = 2'd2;
  localparam logic [1:0] LK_UNREC   = 2'd3;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_BAD_START = 3'd1;
  localparam logic [2:0] ERR_SEC_ALPHA = 3'd2;
  localparam logic [2:0] ERR_NO_CLOSE  = 3'd3;
  localparam logic [2:0] ERR_NO_EQ     = 3'd4;
  localparam logic [2:0] ERR_NO_VALUE  = 3'd5;
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd6;
  localparam logic [2:0] ERR_TRAILING  = 3'd7;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] line_class;
    logic [2:0] pend_err;
  } state_t;

  localparam state_t STATE_RESET = '{phase: PH_LEAD, line_class: LK_EMPTY,
                                     pend_err: ERR_OK};

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] out_char;
    logic [1:0] line_kind;
    logic [2:0] error_code;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_comment(input logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_HASH) || (c == CH_PCT);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return !is_space(c) && (c != CH_DQUOTE) && (c != CH_SQUOTE) && (c != CH_BTICK) &&
           (c != CH_EQ) && (c != CH_LBRK) && (c != CH_RBRK);
  endfunction

  function automatic logic is_unquoted(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_DOT) ||
           (c == CH_COMMA) || (c == CH_MINUS) || (c == CH_PLUS);
  endfunction

endpackage

`default_nettype wire

// File: hdl/ilt_step.sv
// ----------------------------------------------------------------------------
// INI line tokenizer step
// Decodes one byte or line end against the current phase and gives the next
// line state and the token, if any, that the byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

module ilt_step (
  input  var ilt_pkg::state_t  st,
  input  wire logic [7:0]      ch,
  input  wire logic            eol,
  output ilt_pkg::state_t      st_nxt,
  output logic                 emit,
  output ilt_pkg::result_t     res
);

  logic [2:0] end_err;

  always_comb begin
    end_err = st.pend_err;
    case (st.phase)
      ilt_pkg::PH_SEC_FIRST: end_err = ilt_pkg::ERR_SEC_ALPHA;
      ilt_pkg::PH_SEC_NAME:  end_err = ilt_pkg::ERR_NO_CLOSE;
      ilt_pkg::PH_OPT_NAME,
      ilt_pkg::PH_PRE_EQ:    end_err = ilt_pkg::ERR_NO_EQ;
      ilt_pkg::PH_POST_EQ:   end_err = ilt_pkg::ERR_NO_VALUE;
      ilt_pkg::PH_QUOTED,
      ilt_pkg::PH_Q_ESC:     end_err = ilt_pkg::ERR_NO_QUOTE;
      default:               end_err = st.pend_err;
    endcase
  end

  always_comb begin
    st_nxt         = st;
    emit           = 1'b0;
    res.token_kind = ilt_pkg::TK_VAL;
    res.out_char   = ch;
    res.line_kind  = ilt_pkg::LK_EMPTY;
    res.error_code = ilt_pkg::ERR_OK;
    if (eol) begin
      emit           = 1'b1;
      res.token_kind = ilt_pkg::TK_DONE;
      res.out_char   = ilt_pkg::CH_NUL;
      res.line_kind  = st.line_class;
      res.error_code = end_err;
      st_nxt         = ilt_pkg::STATE_RESET;
    end else begin
      case (st.phase)
        ilt_pkg::PH_LEAD: begin
          if (ilt_pkg::is_space(ch)) begin
            st_nxt.phase = ilt_pkg::PH_LEAD;
          end else if (ilt_pkg::is_comment(ch)) begin
            st_nxt.phase = ilt_pkg::PH_IGNORE;
          end else if (ch == ilt_pkg::CH_LBRK) begin
            st_nxt.line_class = ilt_pkg::LK_SECTION;
            st_nxt.phase      = ilt_pkg::PH_SEC_FIRST;
          end else if (ilt_pkg::is_alpha(ch)) begin
            st_nxt.line_class = ilt_pkg::LK_OPTION;
            st_nxt.phase      = ilt_pkg::PH_OPT_NAME;
            emit              = 1'b1;
            res.token_kind    = ilt_pkg::TK_OPT;
          end else begin
            st_nxt.line_class = ilt_pkg::LK_UNREC;
            st_nxt.pend_err   = ilt_pkg::ERR_BAD_START;
            st_nxt.phase      = ilt_pkg::PH_IGNORE;
          end
        end
        ilt_pkg::PH_SEC_FIRST: begin
          if (ilt_pkg::is_alpha(ch)) begin
            st_nxt.phase   = ilt_pkg::PH_SEC_NAME;
            emit           = 1'b1;
            res.token_kind = ilt_pkg::TK_SEC;
          end else begin
            st_nxt.pend_err = ilt_pkg::ERR_SEC_ALPHA;
            st_nxt.phase    = ilt_pkg::PH_IGNORE;
          end
        end
        ilt_pkg::PH_SEC_NAME: begin
          if (ilt_pkg::is_name(ch)) begin
            emit           = 1'b1;
            res.token_kind = ilt_pkg::TK_SEC;
          end else if (ch == ilt_pkg::CH_RBRK) begin
            st_nxt.phase = ilt_pkg::PH_IGNORE;
          end else begin
            st_nxt.pend_err = ilt_pkg::ERR_NO_CLOSE;
            st_nxt.phase    = ilt_pkg::PH_IGNORE;
          end
        end
        ilt_pkg::PH_OPT_NAME: begin
          if (ilt_pkg::is_name(ch)) begin
            emit           = 1'b1;
            res.token_kind = ilt_pkg::TK_OPT;
          end else if (ilt_pkg::is_space(ch)) begin
            st_nxt.phase = ilt_pkg::PH_PRE_EQ;
          end else if (ch == ilt_pkg::CH_EQ) begin
            st_nxt.phase = ilt_pkg::PH_POST_EQ;
          end else begin
            st_nxt.pend_err = ilt_pkg::ERR_NO_EQ;
            st_nxt.phase    = ilt_pkg::PH_IGNORE;
          end
        end
        ilt_pkg::PH_PRE_EQ: begin
          if (ilt_pkg::is_space(ch)) begin
            st_nxt.phase = ilt_pkg::PH_PRE_EQ;
          end else if (ch == ilt_pkg::CH_EQ) begin
            st_nxt.phase = ilt_pkg::PH_POST_EQ;
          end else begin
            st_nxt.pend_err = ilt_pkg::ERR_NO_EQ;
            st_nxt.phase    = ilt_pkg::PH_IGNORE;
          end
        end
        ilt_pkg::PH_POST_EQ: begin
          if (ilt_pkg::is_space(ch)) begin
            st_nxt.phase = ilt_pkg::PH_POST_EQ;
          end else if (ch == ilt_pkg::CH_DQUOTE) begin
            st_nxt.phase = ilt_pkg::PH_QUOTED;
          end else if (ilt_pkg::is_unquoted(ch)) begin
            st_nxt.phase = ilt_pkg::PH_UNQ;
            emit         = 1'b1;
          end else if (ilt_pkg::is_comment(ch)) begin
            st_nxt.phase = ilt_pkg::PH_IGNORE;
          end else begin
            st_nxt.pend_err = ilt_pkg::ERR_TRAILING;
            st_nxt.phase    = ilt_pkg::PH_IGNORE;
          end
        end
        ilt_pkg::PH_UNQ: begin
          if (ilt_pkg::is_unquoted(ch)) begin
            emit = 1'b1;
          end else if (ilt_pkg::is_space(ch)) begin
            st_nxt.phase = ilt_pkg::PH_TRAIL;
          end else if (ilt_pkg::is_comment(ch)) begin
            st_nxt.phase = ilt_pkg::PH_IGNORE;
          end else begin
            st_nxt.pend_err = ilt_pkg::ERR_TRAILING;
            st_nxt.phase    = ilt_pkg::PH_IGNORE;
          end
        end
        ilt_pkg::PH_QUOTED: begin
          if (ch == ilt_pkg::CH_DQUOTE) begin
            st_nxt.phase = ilt_pkg::PH_TRAIL;
          end else if (ch == ilt_pkg::CH_BSLASH) begin
            st_nxt.phase = ilt_pkg::PH_Q_ESC;
          end else begin
            emit = 1'b1;
          end
        end
        ilt_pkg::PH_Q_ESC: begin
          st_nxt.phase = ilt_pkg::PH_QUOTED;
          emit         = 1'b1;
        end
        ilt_pkg::PH_TRAIL: begin
          if (ilt_pkg::is_space(ch)) begin
            st_nxt.phase = ilt_pkg::PH_TRAIL;
          end else if (ilt_pkg::is_comment(ch)) begin
            st_nxt.phase = ilt_pkg::PH_IGNORE;
          end else begin
            st_nxt.pend_err = ilt_pkg::ERR_TRAILING;
            st_nxt.phase    = ilt_pkg::PH_IGNORE;
          end
        end
        default: begin
          st_nxt.phase = ilt_pkg::PH_IGNORE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/ini_line_tokenizer.sv
// Each transfer is captured in the input register, and its result in the output register.
// Throughput: one byte or line end per cycle while the output is not stalled; the phase update is a single decode step.
// Bytes that produce no token are absorbed without a result transfer.
// Reset (rst_n low, synchronous) empties both registers and returns the line
// state to the leading-whitespace phase with no error.
// ----------------------------------------------------------------------------
// INI line tokenizer
// Splits INI text into section name, option name and value bytes and reports
// the line kind and first error at each line end.
// ----------------------------------------------------------------------------
`default_nettype none

module ini_line_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_line_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_token_kind,
  output logic [7:0]      out_char,
  output logic [1:0]      out_line_kind,
  output logic [2:0]      out_error_code
);

  logic              s1_valid_r;
  logic [7:0]        s1_char_r;
  logic              s1_eol_r;
  ilt_pkg::state_t   state_r;
  ilt_pkg::state_t   state_nxt;
  logic              step_emit;
  ilt_pkg::result_t  step_res;
  logic              out_valid_r;
  ilt_pkg::result_t  out_res_r;
  logic              out_free;
  logic              step_fire;

  assign out_free  = !out_valid_r || !out_stall;
  assign step_fire = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;

  ilt_step u_step (
    .st     (state_r),
    .ch     (s1_char_r),
    .eol    (s1_eol_r),
    .st_nxt (state_nxt),
    .emit   (step_emit),
    .res    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ilt_pkg::STATE_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r && step_emit;
      end
      if (step_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_char_code;
      s1_eol_r  <= in_line_end;
    end
    if (step_fire && step_emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_token_kind = out_res_r.token_kind;
  assign out_char       = out_res_r.out_char;
  assign out_line_kind  = out_res_r.line_kind;
  assign out_error_code = out_res_r.error_code;

endmodule

`default_nettype wire

// File: hdl/ilt_checker.sv
// ----------------------------------------------------------------------------
// INI line tokenizer checker
// Port-level checks on the result channel of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ini_line_tokenizer_assert.svh"

module ilt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_token_kind,
  input wire logic [7:0] out_char,
  input wire logic [1:0] out_line_kind,
  input wire logic [2:0] out_error_code
);

  `ILT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_token_kind) && $stable(out_char) && $stable(out_line_kind) && $stable(out_error_code))

  `ILT_ASSERT_SAME(a_byte_fields, out_valid && (out_token_kind != ilt_pkg::TK_DONE), (out_line_kind == ilt_pkg::LK_EMPTY) && (out_error_code == ilt_pkg::ERR_OK))

  `ILT_ASSERT_SAME(a_done_fields, out_valid && (out_token_kind == ilt_pkg::TK_DONE), (out_char == ilt_pkg::CH_NUL) && ((out_line_kind != ilt_pkg::LK_EMPTY) || (out_error_code == ilt_pkg::ERR_OK)))

  `ILT_ASSERT_SAME(a_sec_char, out_valid && (out_token_kind == ilt_pkg::TK_SEC), (out_char != ilt_pkg::CH_SPACE) && (out_char != ilt_pkg::CH_EQ) && (out_char != ilt_pkg::CH_LBRK) && (out_char != ilt_pkg::CH_RBRK))

endmodule

bind ini_line_tokenizer ilt_checker u_ilt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_token_kind (out_token_kind),
  .out_char       (out_char),
  .out_line_kind  (out_line_kind),
  .out_error_code (out_error_code)
);

`default_nettype wire

// File: test/ini_line_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// INI line tokenizer testbench
// Sends short directed lines and then random INI lines, mostly well formed,
// with random gaps on both channels and one long output hold-off. A scoreboard
// predicts every token and line result and compares each output transfer.
// ----------------------------------------------------------------------------

module testbench;

  localparam int TRANSFER_TARGET = 830;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 300;

  class ini_token_board;
    localparam int REPORT_CAP = 100;

    ilt_pkg::phase_t  phase;
    logic [1:0]       line_class;
    logic [2:0]       pend_err;
    ilt_pkg::result_t expected_tokens[$];
    int               mismatches;
    int               checked;
    int               lines_done;

    function new();
      phase      = ilt_pkg::PH_LEAD;
      line_class = ilt_pkg::LK_EMPTY;
      pend_err   = ilt_pkg::ERR_OK;
      mismatches = 0;
      checked    = 0;
      lines_done = 0;
    endfunction

    static function bit byte_is_blank(logic [7:0] c);
      return c == ilt_pkg::CH_SPACE || c == ilt_pkg::CH_TAB || c == ilt_pkg::CH_LF ||
             c == ilt_pkg::CH_CR;
    endfunction

    static function bit byte_is_remark(logic [7:0] c);
      return c == ilt_pkg::CH_SEMI || c == ilt_pkg::CH_HASH || c == ilt_pkg::CH_PCT;
    endfunction

    static function bit byte_is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == ilt_pkg::CH_UNDER;
    endfunction

    static function bit byte_is_name(logic [7:0] c);
      return !byte_is_blank(c) && c != ilt_pkg::CH_DQUOTE && c != ilt_pkg::CH_SQUOTE &&
             c != ilt_pkg::CH_BTICK && c != ilt_pkg::CH_EQ && c != ilt_pkg::CH_LBRK &&
             c != ilt_pkg::CH_RBRK;
    endfunction

    static function bit byte_is_bare(logic [7:0] c);
      return byte_is_letter(c) || (c >= "0" && c <= "9") || c == ilt_pkg::CH_DOT ||
             c == ilt_pkg::CH_COMMA || c == ilt_pkg::CH_MINUS || c == ilt_pkg::CH_PLUS;
    endfunction

    function void push_byte_token(logic [1:0] kind, logic [7:0] c);
      ilt_pkg::result_t tok;
      tok.token_kind  = kind;
      tok.out_char    = c;
      tok.line_kind   = ilt_pkg::LK_EMPTY;
      tok.error_code  = ilt_pkg::ERR_OK;
      expected_tokens = {expected_tokens, tok};
    endfunction

    function void abort_line(logic [2:0] code);
      pend_err = code;
      phase    = ilt_pkg::PH_IGNORE;
    endfunction

    function void close_value(logic [7:0] c);
      if (byte_is_remark(c)) phase = ilt_pkg::PH_IGNORE;
      else abort_line(ilt_pkg::ERR_TRAILING);
    endfunction

    function void predict_tokens(logic [7:0] c, logic line_end);
      ilt_pkg::result_t done;
      logic [2:0]       err;
      if (line_end) begin
        err = pend_err;
        case (phase)
          ilt_pkg::PH_SEC_FIRST: err = ilt_pkg::ERR_SEC_ALPHA;
          ilt_pkg::PH_SEC_NAME:  err = ilt_pkg::ERR_NO_CLOSE;
          ilt_pkg::PH_OPT_NAME,
          ilt_pkg::PH_PRE_EQ:    err = ilt_pkg::ERR_NO_EQ;
          ilt_pkg::PH_POST_EQ:   err = ilt_pkg::ERR_NO_VALUE;
          ilt_pkg::PH_QUOTED,
          ilt_pkg::PH_Q_ESC:     err = ilt_pkg::ERR_NO_QUOTE;
          default:               ;
        endcase
        done.token_kind = ilt_pkg::TK_DONE;
        done.out_char   = ilt_pkg::CH_NUL;
        done.line_kind  = line_class;
        done.error_code = err;
        expected_tokens = {expected_tokens, done};
        phase      = ilt_pkg::PH_LEAD;
        line_class = ilt_pkg::LK_EMPTY;
        pend_err   = ilt_pkg::ERR_OK;
        return;
      end
      case (phase)
        ilt_pkg::PH_LEAD: begin
          if (byte_is_remark(c)) phase = ilt_pkg::PH_IGNORE;
          else if (c == ilt_pkg::CH_LBRK) begin
            line_class = ilt_pkg::LK_SECTION;
            phase      = ilt_pkg::PH_SEC_FIRST;
          end else if (byte_is_letter(c)) begin
            line_class = ilt_pkg::LK_OPTION;
            phase      = ilt_pkg::PH_OPT_NAME;
            push_byte_token(ilt_pkg::TK_OPT, c);
          end else if (!byte_is_blank(c)) begin
            line_class = ilt_pkg::LK_UNREC;
            abort_line(ilt_pkg::ERR_BAD_START);
          end
        end
        ilt_pkg::PH_SEC_FIRST: begin
          if (byte_is_letter(c)) begin
            phase = ilt_pkg::PH_SEC_NAME;
            push_byte_token(ilt_pkg::TK_SEC, c);
          end else abort_line(ilt_pkg::ERR_SEC_ALPHA);
        end
        ilt_pkg::PH_SEC_NAME: begin
          if (byte_is_name(c)) push_byte_token(ilt_pkg::TK_SEC, c);
          else if (c == ilt_pkg::CH_RBRK) phase = ilt_pkg::PH_IGNORE;
          else abort_line(ilt_pkg::ERR_NO_CLOSE);
        end
        ilt_pkg::PH_OPT_NAME: begin
          if (byte_is_name(c)) push_byte_token(ilt_pkg::TK_OPT, c);
          else if (byte_is_blank(c)) phase = ilt_pkg::PH_PRE_EQ;
          else if (c == ilt_pkg::CH_EQ) phase = ilt_pkg::PH_POST_EQ;
          else abort_line(ilt_pkg::ERR_NO_EQ);
        end
        ilt_pkg::PH_PRE_EQ: begin
          if (c == ilt_pkg::CH_EQ) phase = ilt_pkg::PH_POST_EQ;
          else if (!byte_is_blank(c)) abort_line(ilt_pkg::ERR_NO_EQ);
        end
        ilt_pkg::PH_POST_EQ: begin
          if (c == ilt_pkg::CH_DQUOTE) phase = ilt_pkg::PH_QUOTED;
          else if (byte_is_bare(c)) begin
            phase = ilt_pkg::PH_UNQ;
            push_byte_token(ilt_pkg::TK_VAL, c);
          end else if (!byte_is_blank(c)) close_value(c);
        end
        ilt_pkg::PH_UNQ: begin
          if (byte_is_bare(c)) push_byte_token(ilt_pkg::TK_VAL, c);
          else if (byte_is_blank(c)) phase = ilt_pkg::PH_TRAIL;
          else close_value(c);
        end
        ilt_pkg::PH_QUOTED: begin
          if (c == ilt_pkg::CH_DQUOTE) phase = ilt_pkg::PH_TRAIL;
          else if (c == ilt_pkg::CH_BSLASH) phase = ilt_pkg::PH_Q_ESC;
          else push_byte_token(ilt_pkg::TK_VAL, c);
        end
        ilt_pkg::PH_Q_ESC: begin
          phase = ilt_pkg::PH_QUOTED;
          push_byte_token(ilt_pkg::TK_VAL, c);
        end
        ilt_pkg::PH_TRAIL: begin
          if (!byte_is_blank(c)) close_value(c);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("MISMATCH: %s", msg);
    endtask

    task check_token(ilt_pkg::result_t got);
      ilt_pkg::result_t want;
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d char %02h",
                                  got.token_kind, got.out_char));
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (want.token_kind == ilt_pkg::TK_DONE) lines_done++;
      if (got.token_kind !== want.token_kind)
        report_mismatch($sformatf("token_kind %0d, expected %0d",
                                  got.token_kind, want.token_kind));
      if (got.out_char !== want.out_char)
        report_mismatch($sformatf("out_char %02h, expected %02h",
                                  got.out_char, want.out_char));
      if (got.line_kind !== want.line_kind)
        report_mismatch($sformatf("line_kind %0d, expected %0d",
                                  got.line_kind, want.line_kind));
      if (got.error_code !== want.error_code)
        report_mismatch($sformatf("error_code %0d, expected %0d",
                                  got.error_code, want.error_code));
    endtask

    function int pending();
      return expected_tokens.size();
    endfunction

    task check_drained();
      if (expected_tokens.size() > 0)
        report_mismatch($sformatf("%0d expected results never arrived",
                                  expected_tokens.size()));
    endtask
  endclass

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_char_code = 8'h00;
  logic       in_line_end  = 1'b0;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_token_kind;
  logic [7:0] out_char;
  logic [1:0] out_line_kind;
  logic [2:0] out_error_code;

  ini_token_board board;
  logic [7:0]     line_bytes[$];
  int             sent_count  = 0;
  int             line_count  = 0;
  int             cycle_count = 0;
  int             hold_off    = 0;
  int             stall_left  = 0;
  bit             send_quiet  = 1'b0;
  bit             recv_quiet  = 1'b0;

  ini_line_tokenizer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_line_end    (in_line_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_char       (out_char),
    .out_line_kind  (out_line_kind),
    .out_error_code (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap(bit quiet);
    if (quiet) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [7:0] pick_any();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return ilt_pkg::CH_SPACE;
      1:       return ilt_pkg::CH_TAB;
      2:       return ilt_pkg::CH_LF;
      default: return ilt_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_remark();
    case ($urandom_range(0, 2))
      0:       return ilt_pkg::CH_SEMI;
      1:       return ilt_pkg::CH_HASH;
      default: return ilt_pkg::CH_PCT;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r == 52) return ilt_pkg::CH_UNDER;
    if (r < 26) return 8'("A" + r);
    return 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] pick_name_char();
    logic [7:0] c;
    do c = pick_any(); while (!ini_token_board::byte_is_name(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_bare();
    logic [7:0] c;
    do c = pick_any(); while (!ini_token_board::byte_is_bare(c));
    return c;
  endfunction

  task automatic add_byte(logic [7:0] c);
    line_bytes = {line_bytes, c};
  endtask

  task automatic add_blanks(int n);
    repeat (n) add_byte(pick_blank());
  endtask

  task automatic add_random(int n);
    repeat (n) add_byte(pick_any());
  endtask

  task automatic load_text(string s);
    line_bytes.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic build_section();
    add_byte(ilt_pkg::CH_LBRK);
    add_byte(pick_letter());
    repeat ($urandom_range(0, 5)) add_byte(pick_name_char());
    add_byte(ilt_pkg::CH_RBRK);
    if ($urandom_range(0, 3) == 0) add_random($urandom_range(1, 3));
  endtask

  task automatic build_option();
    int         form;
    logic [7:0] c;
    add_byte(pick_letter());
    repeat ($urandom_range(0, 5)) add_byte(pick_name_char());
    add_blanks($urandom_range(0, 2));
    add_byte(ilt_pkg::CH_EQ);
    add_blanks($urandom_range(0, 2));
    form = $urandom_range(0, 4);
    if (form <= 1) begin
      add_byte(ilt_pkg::CH_DQUOTE);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 4) == 0) begin
          add_byte(ilt_pkg::CH_BSLASH);
          add_byte(pick_any());
        end else begin
          do c = pick_any(); while (c == ilt_pkg::CH_DQUOTE || c == ilt_pkg::CH_BSLASH);
          add_byte(c);
        end
      end
      add_byte(ilt_pkg::CH_DQUOTE);
    end else if (form <= 3) begin
      repeat ($urandom_range(1, 5)) add_byte(pick_bare());
    end
    add_blanks($urandom_range(0, 2));
    if ($urandom_range(0, 2) == 0) begin
      add_byte(pick_remark());
      add_random($urandom_range(0, 3));
    end
  endtask

  task automatic build_line();
    int kind;
    int cut;
    line_bytes.delete();
    add_blanks($urandom_range(0, 2));
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1:       build_section();
      2, 3, 4, 5: build_option();
      6: begin
        if ($urandom_range(0, 1) == 1) begin
          add_byte(pick_remark());
          add_random($urandom_range(0, 4));
        end
      end
      7, 8: begin
        if (kind == 7) build_section();
        else build_option();
        cut = $urandom_range(0, line_bytes.size() - 1);
        if ($urandom_range(0, 1) == 1) line_bytes[cut] = pick_any();
        else while (line_bytes.size() > cut) void'(line_bytes.pop_back());
      end
      default: add_random($urandom_range(1, 8));
    endcase
  endtask

  task automatic send_transfer(logic [7:0] c, logic line_end);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_line_end  <= line_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.predict_tokens(c, line_end);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_transfer(line_bytes[i], 1'b0);
    send_transfer(pick_any(), 1'b1);
    line_count++;
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_token({out_token_kind, out_char, out_line_kind, out_error_code});
      stall_left = pick_gap(recv_quiet);
    end
  end

  initial begin
    int line_no;
    board = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    load_text("");
    send_line();
    load_text("#");
    send_line();
    load_text("[a]");
    send_line();
    load_text("[1");
    send_line();
    load_text("[a");
    send_line();
    load_text("a");
    add_byte(8'h00);
    add_byte(8'hFF);
    send_line();
    load_text("a=");
    send_line();
    load_text("a=\"\\");
    send_line();
    load_text("a=1!");
    send_line();
    load_text("1");
    send_line();

    line_no = 0;
    while (sent_count < TRANSFER_TARGET) begin
      if (line_no == 10) begin
        hold_off   = HOLD_OFF_CYCLES;
        send_quiet = 1'b1;
        repeat (4) begin
          line_bytes.delete();
          build_option();
          send_line();
        end
        send_quiet = 1'b0;
      end
      if ($urandom_range(0, 24) == 0) send_quiet = !send_quiet;
      if ($urandom_range(0, 24) == 0) recv_quiet = !recv_quiet;
      build_line();
      send_line();
      line_no++;
    end
    in_valid <= 1'b0;

    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.check_drained();

    $display("Sent %0d transfers over %0d lines, with random gaps and a long output hold-off.",
             sent_count, line_count);
    $display("Checked %0d results, %0d of them line ends; %0d mismatches.",
             board.checked, board.lines_done, board.mismatches);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ilt_pkg.sv
hdl/ilt_step.sv
hdl/ini_line_tokenizer.sv
hdl/ilt_checker.sv
test/ini_line_tokenizer_tb.sv
